### src/srp_pkg.sv
// shared types, widths and codes of the stroke point resampler
package srp_pkg;

    localparam int XY_W         = 16;
    localparam int P_W          = 13;
    localparam int MAG_W        = XY_W;
    localparam int DLT_W        = XY_W + 1;
    localparam int SQ_W         = 2 * DLT_W;
    localparam int ROOT_W       = SQ_W / 2;
    localparam int DIVN_W       = MAG_W + 1;
    localparam int STEP_W       = 8;
    localparam int ACC_W        = DLT_W + 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int MAX_STEPS_DEF = 64;
    localparam int LANES        = 3;
    localparam int LANE_W       = 2;

    localparam logic [P_W-1:0]    P_FULL     = 13'd4096;
    localparam logic [STEP_W-1:0] STEP_RESET = 8'd32;
    localparam logic              MODE_RESET = 1'b1;

    localparam logic [LANE_W-1:0] LANE_X = 2'd0;
    localparam logic [LANE_W-1:0] LANE_Y = 2'd1;
    localparam logic [LANE_W-1:0] LANE_P = 2'd2;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_DRAG    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 1'b0,
        CFG_STEP = 1'b1
    } t_cfg_idx;

    localparam logic MODE_SMOOTH   = 1'b0;
    localparam logic MODE_RESAMPLE = 1'b1;

    typedef struct packed {
        t_op                     operation;
        logic                    layer_visible;
        logic signed [XY_W-1:0]  pos_x;
        logic signed [XY_W-1:0]  pos_y;
        logic [P_W-1:0]          pen_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [XY_W-1:0]  point_x;
        logic signed [XY_W-1:0]  point_y;
        logic [P_W-1:0]          point_pressure;
        logic                    last;
    } t_out_item;

endpackage

### src/stroke_point_resampler_unit.sv
// stroke point resampler top level: event decode, sequencing and point stepping
//
//  channel   direction  handshake               payload
//  in        into       i_in_valid / o_in_stall  i_in_item  (srp_pkg::t_in_item)
//  out       out of     o_out_valid / i_out_stall o_out_item (srp_pkg::t_out_item)
//  cfg       into       i_cfg_we                i_cfg_idx, i_cfg_data
//
//  release and ignored items pass back to back; a press holds the input in S_ONE
//  until its point is taken into the point register. a drag holds it through sum
//  of squares and square root, then smoothing emits at most one point via S_ONE,
//  while resampling adds step division, per-lane division and one point per cycle.
//  synchronous active-low reset; config returns to mode 1, step 32.
//  an output stall holds the point register and pauses point stepping.
module stroke_point_resampler_unit #(
    parameter int MAX_STEPS = srp_pkg::MAX_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  srp_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output srp_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [srp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int XW    = srp_pkg::XY_W;
    localparam int PW    = srp_pkg::P_W;
    localparam int MW    = srp_pkg::MAG_W;
    localparam int DW    = srp_pkg::DLT_W;
    localparam int AW    = srp_pkg::ACC_W;
    localparam int SW    = srp_pkg::STEP_W;
    localparam int RW    = srp_pkg::ROOT_W;
    localparam int NW    = srp_pkg::DIVN_W;
    localparam int SQW   = srp_pkg::SQ_W;
    localparam int LN    = srp_pkg::LANES;
    localparam int LW    = srp_pkg::LANE_W;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SQ   = 7'b0000010,
        S_SQRT = 7'b0000100,
        S_DIVN = 7'b0001000,
        S_DIVL = 7'b0010000,
        S_STEP = 7'b0100000,
        S_ONE  = 7'b1000000
    } t_state;

    function automatic logic [MW-1:0] f_mag(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] t;
        t = d[DW-1] ? -d : d;
        return t[MW-1:0];
    endfunction

    // control
    t_state          r_state, n_state;
    logic            r_mode;
    logic [SW-1:0]   r_step;
    logic            r_open, n_open;
    logic signed [XW-1:0] r_prev_x, n_prev_x;
    logic signed [XW-1:0] r_prev_y, n_prev_y;
    logic [PW-1:0]   r_prev_p, n_prev_p;
    logic            r_sq_start, n_sq_start;
    logic            r_rt_start, n_rt_start;
    logic            r_dv_start, n_dv_start;
    logic            r_out_valid, n_out_valid;
    logic [LW-1:0]   r_lane, n_lane;
    logic [CNT_W-1:0] r_idx, n_idx;

    // payload
    logic signed [XW-1:0] r_pen_x, n_pen_x;
    logic signed [XW-1:0] r_pen_y, n_pen_y;
    logic [PW-1:0]   r_pen_p, n_pen_p;
    logic signed [DW-1:0] r_delta [LN];
    logic signed [DW-1:0] n_delta [LN];
    logic signed [AW-1:0] r_base [LN];
    logic signed [AW-1:0] n_base [LN];
    logic signed [AW-1:0] r_qs [LN];
    logic signed [AW-1:0] n_qs [LN];
    logic [SW-1:0]   r_rs [LN];
    logic [SW-1:0]   n_rs [LN];
    logic signed [AW-1:0] r_acc_q [LN];
    logic signed [AW-1:0] n_acc_q [LN];
    logic [SW-1:0]   r_acc_r [LN];
    logic [SW-1:0]   n_acc_r [LN];
    logic [CNT_W-1:0] r_steps, n_steps;
    logic [SW-1:0]   r_den, n_den;
    logic [NW-1:0]   r_dv_num, n_dv_num;
    logic [SW-1:0]   r_dv_den, n_dv_den;
    srp_pkg::t_out_item r_one, n_one;
    srp_pkg::t_out_item r_out, n_out;

    // engine results
    logic            sq_done;
    logic [SQW-1:0]  sq_sum;
    logic            rt_done;
    logic [RW-1:0]   rt_root;
    logic            rt_rem_nz;
    logic            dv_done;
    logic [NW-1:0]   dv_quot;
    logic [SW-1:0]   dv_rem;

    // helpers
    logic            accept;
    logic            out_free;
    logic [SW-1:0]   s_eff;
    logic [PW-1:0]   pp_sat;
    logic [CNT_W-1:0] sat_steps;
    logic [SW-1:0]   sat_den;
    logic            lane_neg;
    logic signed [AW-1:0] q_pos;
    logic signed [AW-1:0] lane_q;
    logic [SW-1:0]   lane_r;
    logic [LW-1:0]   next_lane;
    logic signed [DW+2:0] sm_t [2];
    logic [SW-1:0]   st_sum [LN];
    logic            st_cy [LN];
    logic [SW-1:0]   st_r [LN];
    logic signed [AW-1:0] st_q [LN];
    logic signed [AW-1:0] st_pt [LN];
    logic            st_last;

    srp_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_a     (f_mag(r_delta[srp_pkg::LANE_X])),
        .i_b     (f_mag(r_delta[srp_pkg::LANE_Y])),
        .o_done  (sq_done),
        .o_sum   (sq_sum)
    );

    srp_isqrt u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_rt_start),
        .i_val    (sq_sum),
        .o_done   (rt_done),
        .o_root   (rt_root),
        .o_rem_nz (rt_rem_nz)
    );

    srp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dv_start),
        .i_num   (r_dv_num),
        .i_den   (r_dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot),
        .o_rem   (dv_rem)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign s_eff    = (r_step == '0) ? SW'(1) : r_step;
    assign pp_sat   = (i_in_item.pen_pressure > srp_pkg::P_FULL) ?
                      srp_pkg::P_FULL : i_in_item.pen_pressure;

    // step count saturation and doubled denominator
    always_comb begin
        if (dv_quot > NW'(MAX_STEPS)) begin
            sat_steps = CNT_W'(MAX_STEPS);
        end else begin
            sat_steps = dv_quot[CNT_W-1:0];
        end
        sat_den = SW'({sat_steps, 1'b0});
    end

    // floor division of a signed lane delta from the magnitude quotient
    always_comb begin
        lane_neg  = r_delta[r_lane][DW-1];
        q_pos     = AW'(dv_quot);
        next_lane = r_lane + LW'(1);
        if (!lane_neg) begin
            lane_q = q_pos;
            lane_r = dv_rem;
        end else if (dv_rem == '0) begin
            lane_q = -q_pos;
            lane_r = '0;
        end else begin
            lane_q = -q_pos - AW'(1);
            lane_r = r_den - dv_rem;
        end
    end

    // smoothing offset: floor((3 * delta + 2) / 4)
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sm_t[l] = ((DW + 3)'(r_delta[l]) <<< 1) + (DW + 3)'(r_delta[l]) +
                      (DW + 3)'(2);
        end
    end

    // per-lane incremental interpolation
    always_comb begin
        for (int l = 0; l < LN; l++) begin
            st_sum[l] = r_acc_r[l] + r_rs[l];
            st_cy[l]  = (st_sum[l] >= r_den);
            st_r[l]   = st_cy[l] ? st_sum[l] - r_den : st_sum[l];
            st_q[l]   = r_acc_q[l] + r_qs[l] + AW'(st_cy[l]);
            st_pt[l]  = r_base[l] + st_q[l];
        end
        st_last = (r_idx == r_steps);
    end

    always_comb begin
        n_state     = r_state;
        n_open      = r_open;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_prev_p    = r_prev_p;
        n_sq_start  = 1'b0;
        n_rt_start  = 1'b0;
        n_dv_start  = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_lane      = r_lane;
        n_idx       = r_idx;
        n_pen_x     = r_pen_x;
        n_pen_y     = r_pen_y;
        n_pen_p     = r_pen_p;
        n_delta     = r_delta;
        n_base      = r_base;
        n_qs        = r_qs;
        n_rs        = r_rs;
        n_acc_q     = r_acc_q;
        n_acc_r     = r_acc_r;
        n_steps     = r_steps;
        n_den       = r_den;
        n_dv_num    = r_dv_num;
        n_dv_den    = r_dv_den;
        n_one       = r_one;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_item.operation)
                        srp_pkg::OP_PRESS: begin
                            if (i_in_item.layer_visible) begin
                                n_open   = 1'b1;
                                n_prev_x = i_in_item.pos_x;
                                n_prev_y = i_in_item.pos_y;
                                n_prev_p = pp_sat;
                                n_one    = '{point_x: i_in_item.pos_x,
                                             point_y: i_in_item.pos_y,
                                             point_pressure: pp_sat,
                                             last: 1'b1};
                                n_state  = S_ONE;
                            end
                        end
                        srp_pkg::OP_RELEASE: begin
                            n_open = 1'b0;
                        end
                        srp_pkg::OP_DRAG: begin
                            if (r_open) begin
                                n_pen_x = i_in_item.pos_x;
                                n_pen_y = i_in_item.pos_y;
                                n_pen_p = pp_sat;
                                n_delta[srp_pkg::LANE_X] = DW'(i_in_item.pos_x) -
                                                           DW'(r_prev_x);
                                n_delta[srp_pkg::LANE_Y] = DW'(i_in_item.pos_y) -
                                                           DW'(r_prev_y);
                                n_delta[srp_pkg::LANE_P] = $signed(DW'(pp_sat)) -
                                                           $signed(DW'(r_prev_p));
                                n_base[srp_pkg::LANE_X] = AW'(r_prev_x);
                                n_base[srp_pkg::LANE_Y] = AW'(r_prev_y);
                                n_base[srp_pkg::LANE_P] = $signed(AW'(r_prev_p));
                                n_sq_start = 1'b1;
                                n_state    = S_SQ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    n_rt_start = 1'b1;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (rt_done) begin
                    if (r_mode == srp_pkg::MODE_SMOOTH) begin
                        // strictly farther than one step
                        if (rt_root > RW'(s_eff) ||
                            (rt_root == RW'(s_eff) && rt_rem_nz)) begin
                            n_prev_x = r_prev_x + sm_t[0][XW+1:2];
                            n_prev_y = r_prev_y + sm_t[1][XW+1:2];
                            n_prev_p = r_pen_p;
                            n_one    = '{point_x: r_prev_x + sm_t[0][XW+1:2],
                                         point_y: r_prev_y + sm_t[1][XW+1:2],
                                         point_pressure: r_pen_p,
                                         last: 1'b1};
                            n_state  = S_ONE;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else if (rt_root < RW'(s_eff)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_dv_num   = NW'(rt_root);
                        n_dv_den   = s_eff;
                        n_dv_start = 1'b1;
                        n_state    = S_DIVN;
                    end
                end
            end
            S_DIVN: begin
                if (dv_done) begin
                    n_steps    = sat_steps;
                    n_den      = sat_den;
                    n_lane     = srp_pkg::LANE_X;
                    n_dv_num   = {f_mag(r_delta[srp_pkg::LANE_X]), 1'b0};
                    n_dv_den   = sat_den;
                    n_dv_start = 1'b1;
                    n_state    = S_DIVL;
                end
            end
            S_DIVL: begin
                if (dv_done) begin
                    n_qs[r_lane] = lane_q;
                    n_rs[r_lane] = lane_r;
                    if (r_lane == srp_pkg::LANE_P) begin
                        for (int l = 0; l < LN; l++) begin
                            n_acc_q[l] = '0;
                            n_acc_r[l] = SW'(r_steps);
                        end
                        n_idx   = CNT_W'(1);
                        n_state = S_STEP;
                    end else begin
                        n_lane     = next_lane;
                        n_dv_num   = {f_mag(r_delta[next_lane]), 1'b0};
                        n_dv_start = 1'b1;
                    end
                end
            end
            S_STEP: begin
                if (out_free) begin
                    n_acc_q     = st_q;
                    n_acc_r     = st_r;
                    n_out       = '{point_x: st_pt[srp_pkg::LANE_X][XW-1:0],
                                    point_y: st_pt[srp_pkg::LANE_Y][XW-1:0],
                                    point_pressure: st_pt[srp_pkg::LANE_P][PW-1:0],
                                    last: st_last};
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + CNT_W'(1);
                    if (st_last) begin
                        n_prev_x = r_pen_x;
                        n_prev_y = r_pen_y;
                        n_prev_p = r_pen_p;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (out_free) begin
                    n_out       = r_one;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_p    <= '0;
            r_sq_start  <= 1'b0;
            r_rt_start  <= 1'b0;
            r_dv_start  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lane      <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_prev_p    <= n_prev_p;
            r_sq_start  <= n_sq_start;
            r_rt_start  <= n_rt_start;
            r_dv_start  <= n_dv_start;
            r_out_valid <= n_out_valid;
            r_lane      <= n_lane;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pen_x  <= n_pen_x;
        r_pen_y  <= n_pen_y;
        r_pen_p  <= n_pen_p;
        r_delta  <= n_delta;
        r_base   <= n_base;
        r_qs     <= n_qs;
        r_rs     <= n_rs;
        r_acc_q  <= n_acc_q;
        r_acc_r  <= n_acc_r;
        r_steps  <= n_steps;
        r_den    <= n_den;
        r_dv_num <= n_dv_num;
        r_dv_den <= n_dv_den;
        r_one    <= n_one;
        r_out    <= n_out;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= srp_pkg::MODE_RESET;
            r_step <= srp_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srp_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                srp_pkg::CFG_STEP: r_step <= i_cfg_data[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_step_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_idx >= CNT_W'(1) && r_idx <= r_steps))
        else $error("point index outside the step count");

    a_step_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |->
        (r_acc_r[srp_pkg::LANE_X] < r_den && r_acc_r[srp_pkg::LANE_Y] < r_den &&
         r_acc_r[srp_pkg::LANE_P] < r_den))
        else $error("interpolation remainder not below denominator");

    a_last_lands_on_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && out_free && st_last) |=>
        (r_state == S_IDLE && r_prev_x == o_out_item.point_x &&
         r_prev_y == o_out_item.point_y))
        else $error("final resampled point differs from stored position");

    a_more_points_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> (r_state == S_STEP))
        else $error("non-final point without further points in progress");

endmodule

### src/srp_sumsq.sv
// bit-serial sum of two squares, one multiplier bit per cycle
module srp_sumsq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [srp_pkg::MAG_W-1:0]  i_a,
    input  logic [srp_pkg::MAG_W-1:0]  i_b,
    output logic                       o_done,
    output logic [srp_pkg::SQ_W-1:0]   o_sum
);
    localparam int MW = srp_pkg::MAG_W;
    localparam int SW = srp_pkg::SQ_W;
    localparam int CW = $clog2(MW);

    logic          r_busy;
    logic          r_second;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_mc;
    logic [MW-1:0] r_mp;
    logic [MW-1:0] r_b;
    logic [SW-1:0] r_acc;
    logic [SW-1:0] n_acc;
    logic          wrap;

    assign n_acc = r_mp[0] ? r_acc + r_mc : r_acc;
    assign wrap  = (r_cnt == CW'(MW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_second <= 1'b0;
                r_cnt    <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (wrap) begin
                    r_cnt <= '0;
                    if (!r_second) begin
                        r_second <= 1'b1;
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc  <= SW'(i_a);
            r_mp  <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_mc  <= r_mc << 1;
            r_mp  <= r_mp >> 1;
            // second operand takes over after the first pass
            if (wrap && !r_second) begin
                r_mc <= SW'(r_b);
                r_mp <= r_b;
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

### src/srp_isqrt.sv
// digit-serial integer square root, one root bit per cycle
module srp_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [srp_pkg::SQ_W-1:0]    i_val,
    output logic                        o_done,
    output logic [srp_pkg::ROOT_W-1:0]  o_root,
    output logic                        o_rem_nz
);
    localparam int SW = srp_pkg::SQ_W;
    localparam int RW = srp_pkg::ROOT_W;
    localparam int EW = RW + 2;
    localparam int CW = $clog2(RW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_val;
    logic [RW-1:0] r_root;
    logic [EW-1:0] r_rem;
    logic [EW+1:0] sh;
    logic [EW+1:0] trial;
    logic          ge;
    logic [EW+1:0] diff;

    assign sh    = {r_rem, r_val[SW-1 -: 2]};
    assign trial = (EW + 2)'({r_root, 2'b01});
    assign ge    = (sh >= trial);
    assign diff  = ge ? sh - trial : sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_val  <= r_val << 2;
            r_root <= {r_root[RW-2:0], ge};
            r_rem  <= diff[EW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_root   = r_root;
    assign o_rem_nz = |r_rem;

endmodule

### src/srp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module srp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [srp_pkg::DIVN_W-1:0]  i_num,
    input  logic [srp_pkg::STEP_W-1:0]  i_den,
    output logic                        o_done,
    output logic [srp_pkg::DIVN_W-1:0]  o_quot,
    output logic [srp_pkg::STEP_W-1:0]  o_rem
);
    localparam int NW = srp_pkg::DIVN_W;
    localparam int DW = srp_pkg::STEP_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;

    assign t    = {r_rem, r_q[NW-1]};
    assign ge   = (t >= {1'b0, r_d});
    assign diff = ge ? t - {1'b0, r_d} : t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= diff[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

### tb/stroke_point_resampler_unit_tb.sv
// self-checking testbench for the stroke point resampler: pen events in, predicted points out
`timescale 1ns / 100ps

module stroke_point_resampler_unit_tb;
    import srp_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 38;
    localparam int MAX_REPORTS    = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    stroke_point_resampler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // pen events waiting to be offered, points still owed by the block
    t_in_item  pending_events[$];
    t_out_item expected_points[$];

    // predictor copy of the registers and of the last emitted point
    logic              cfg_mode = MODE_RESET;
    logic [STEP_W-1:0] cfg_step = STEP_RESET;
    longint            last_x = 0;
    longint            last_y = 0;
    longint            last_p = 0;
    bit                pen_open = 1'b0;

    int mismatches = 0;
    int quiet_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int pat_kind = 0;
    int pat_left = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    t_out_item want;

    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint root;
        longint trial;
        int b;
        root = 0;
        for (b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic void push_point(input longint x, input longint y, input longint p,
                                       input bit fin);
        t_out_item pt;
        pt.point_x        = XY_W'(x);
        pt.point_y        = XY_W'(y);
        pt.point_pressure = P_W'(p);
        pt.last           = fin;
        expected_points.push_back(pt);
    endfunction

    function automatic void predict_points(input t_in_item ev);
        longint px, py, pp, dx, dy, dp, d2, s, n, k;
        px = $signed(ev.pos_x);
        py = $signed(ev.pos_y);
        pp = ev.pen_pressure;
        if (pp > P_FULL) pp = P_FULL;
        case (ev.operation)
            OP_PRESS: begin
                if (ev.layer_visible) begin
                    pen_open = 1'b1;
                    last_x = px;
                    last_y = py;
                    last_p = pp;
                    push_point(px, py, pp, 1'b1);
                end
            end
            OP_RELEASE: begin
                pen_open = 1'b0;
            end
            OP_DRAG: begin
                if (pen_open) begin
                    s  = (cfg_step == 0) ? 1 : longint'(cfg_step);
                    dx = px - last_x;
                    dy = py - last_y;
                    dp = pp - last_p;
                    d2 = dx * dx + dy * dy;
                    if (cfg_mode == MODE_SMOOTH) begin
                        // one point three quarters of the way, halves round up
                        if (d2 > s * s) begin
                            last_x = last_x + floor_quot(3 * dx + 2, 4);
                            last_y = last_y + floor_quot(3 * dy + 2, 4);
                            last_p = pp;
                            push_point(last_x, last_y, last_p, 1'b1);
                        end
                    end else if (d2 >= s * s) begin
                        n = int_sqrt(d2) / s;
                        if (n > MAX_STEPS_DEF) n = MAX_STEPS_DEF;
                        if (n < 1) n = 1;
                        for (k = 1; k <= n; k++) begin
                            push_point(last_x + floor_quot(2 * dx * k + n, 2 * n),
                                       last_y + floor_quot(2 * dy * k + n, 2 * n),
                                       last_p + floor_quot(2 * dp * k + n, 2 * n),
                                       k == n);
                        end
                        last_x = px;
                        last_y = py;
                        last_p = pp;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_event(input t_op op, input bit vis, input int x, input int y,
                                        input int p);
        t_in_item ev;
        ev.operation     = op;
        ev.layer_visible = vis;
        ev.pos_x         = XY_W'(x);
        ev.pos_y         = XY_W'(y);
        ev.pen_pressure  = P_W'(p);
        pending_events.push_back(ev);
    endfunction

    function automatic int clamp_xy(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int rand_pressure();
        if ($urandom_range(0, 9) == 0) return $urandom_range(4097, 8191);
        return $urandom_range(0, 4096);
    endfunction

    function automatic void log_mismatch(input string what, input t_out_item exp_pt,
                                         input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected x=%0d y=%0d p=%0d last=%0b, got x=%0d y=%0d p=%0d last=%0b",
                     what, exp_pt.point_x, exp_pt.point_y, exp_pt.point_pressure, exp_pt.last,
                     got.point_x, got.point_y, got.point_pressure, got.last);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MODE) cfg_mode = val[0];
        else cfg_step = val;
    endtask

    // block is idle once all items are in, all points out, and silent drags have had time
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_events.size() != 0 || i_in_valid || expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic gen_stroke_phase(input int n_items);
        int made, drags, s, kind, gx, gy, dx, dy, j;
        made = 0;
        gx = 0;
        gy = 0;
        s = (cfg_step == 0) ? 1 : int'(cfg_step);
        @(negedge i_clk);
        while (made < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                // well-formed stroke with random content
                if ($urandom_range(0, 1) == 0) begin
                    gx = int'($urandom_range(0, 65535)) - 32768;
                    gy = int'($urandom_range(0, 65535)) - 32768;
                end else begin
                    gx = int'($urandom_range(0, 4000)) - 2000;
                    gy = int'($urandom_range(0, 4000)) - 2000;
                end
                queue_event(OP_PRESS, $urandom_range(0, 9) != 0, gx, gy, rand_pressure());
                drags = $urandom_range(1, 8);
                for (j = 0; j < drags; j++) begin
                    kind = $urandom_range(0, 9);
                    if (kind <= 5) begin
                        dx = int'($urandom_range(0, 8 * s)) - 4 * s;
                        dy = int'($urandom_range(0, 8 * s)) - 4 * s;
                    end else if (kind <= 7) begin
                        dx = int'($urandom_range(0, 2 * s)) - s;
                        dy = int'($urandom_range(0, 2 * s)) - s;
                    end else if (kind == 8) begin
                        dx = int'($urandom_range(0, 65535)) - 32768 - gx;
                        dy = int'($urandom_range(0, 65535)) - 32768 - gy;
                    end else begin
                        dx = ($urandom_range(0, 1) ? 70 * s : -70 * s) + int'($urandom_range(0, 7));
                        dy = ($urandom_range(0, 1) ? 70 * s : -70 * s) + int'($urandom_range(0, 7));
                    end
                    gx = clamp_xy(gx + dx);
                    gy = clamp_xy(gy + dy);
                    queue_event(OP_DRAG, 1'($urandom_range(0, 1)), gx, gy, rand_pressure());
                end
                if ($urandom_range(0, 99) < 85)
                    queue_event(OP_RELEASE, 1'($urandom_range(0, 1)), gx, gy, rand_pressure());
                made += drags + 2;
            end else begin
                // noise: any operation, any field value
                queue_event(t_op'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            int'($urandom_range(0, 65535)) - 32768,
                            int'($urandom_range(0, 65535)) - 32768,
                            $urandom_range(0, 8191));
                made++;
            end
        end
    endtask

    // sender: bursts of items with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) predict_points(i_in_item);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    i_in_item  <= pending_events.pop_front();
                    i_in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall patterns that change over time, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (pat_left == 0) begin
                pat_kind = $urandom_range(0, 3);
                pat_left = $urandom_range(20, 200);
            end
            pat_left--;
            case (pat_kind)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= (pat_left % 3 == 0);
            endcase
        end
    end

    // point checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                log_mismatch("point with nothing expected", '0, o_out_item);
            end else begin
                want = expected_points.pop_front();
                if (o_out_item.point_x !== want.point_x ||
                    o_out_item.point_y !== want.point_y ||
                    o_out_item.point_pressure !== want.point_pressure ||
                    o_out_item.last !== want.last)
                    log_mismatch("point mismatch", want, o_out_item);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        logic [CFG_DATA_W-1:0] step_pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // resample mode at reset spacing
        queue_event(OP_DRAG, 1'b1, 100, 100, 500);          // drag with no stroke
        queue_event(OP_PRESS, 1'b0, 50, 50, 1000);          // hidden press
        queue_event(OP_PRESS, 1'b1, 0, 0, 0);
        queue_event(OP_DRAG, 1'b1, 10, 10, 100);            // shorter than the spacing
        queue_event(OP_DRAG, 1'b1, 32, 0, 4096);            // exactly one spacing
        queue_event(OP_DRAG, 1'b1, 32767, 32767, 8191);     // saturated count, pressure over full
        queue_event(OP_DRAG, 1'b1, -32768, -32768, 0);
        queue_event(OP_DRAG, 1'b1, -32700, -32768, 1);
        queue_event(OP_NONE, 1'b1, 5, 5, 5);
        queue_event(OP_PRESS, 1'b1, -100, 77, 2048);        // press while open
        queue_event(OP_DRAG, 1'b1, -37, 140, 3000);         // rounding of halves
        queue_event(OP_RELEASE, 1'b1, 0, 0, 0);
        queue_event(OP_DRAG, 1'b1, 0, 0, 0);                // drag after release
        wait_drained();

        // smoothing at the widest spacing
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_SMOOTH));
        write_reg(CFG_STEP, 8'd255);
        @(negedge i_clk);
        queue_event(OP_PRESS, 1'b1, 0, 0, 100);
        queue_event(OP_DRAG, 1'b1, 255, 0, 200);            // equal to the spacing, no point
        queue_event(OP_DRAG, 1'b1, 256, 0, 8191);
        queue_event(OP_DRAG, 1'b1, -1, -1, 5);
        queue_event(OP_DRAG, 1'b1, 32767, -32768, 4096);
        queue_event(OP_RELEASE, 1'b0, 0, 0, 0);
        wait_drained();

        // spacing of zero behaves as one
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_RESAMPLE));
        write_reg(CFG_STEP, 8'd0);
        @(negedge i_clk);
        queue_event(OP_PRESS, 1'b1, 1, 1, 0);
        queue_event(OP_DRAG, 1'b1, 2, 1, 4096);
        queue_event(OP_DRAG, 1'b1, 5, 5, 7);
        queue_event(OP_RELEASE, 1'b1, 5, 5, 7);
        wait_drained();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: step_pick = 8'd1;
                1: step_pick = 8'd255;
                3: step_pick = 8'd16;
                default: step_pick = CFG_DATA_W'($urandom_range(2, 254));
            endcase
            write_reg(CFG_MODE, CFG_DATA_W'(ph[0] ? MODE_SMOOTH : MODE_RESAMPLE));
            write_reg(CFG_STEP, step_pick);
            if (ph == 2) hold_req = 1'b1;
            gen_stroke_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
